// ===== rtl/cbts_pkg.sv =====
`default_nettype none
package cbts_pkg;

  localparam int unsigned CountWidth = 6;
  localparam int unsigned Seg1Width  = 5;
  localparam int unsigned Seg2Width  = 4;
  localparam int unsigned SjwWidth   = 3;
  localparam int unsigned CfgWidth   = 5;
  localparam int unsigned IndexWidth = 2;

  // segment codes
  localparam logic [1:0] SEG_SYNC = 2'd0;
  localparam logic [1:0] SEG_P1   = 2'd1;
  localparam logic [1:0] SEG_P2   = 2'd2;
  localparam logic [1:0] SEG_HS   = 2'd3;

  // register indexes
  localparam logic [IndexWidth-1:0] REG_PHASE1 = 2'd0;
  localparam logic [IndexWidth-1:0] REG_PHASE2 = 2'd1;
  localparam logic [IndexWidth-1:0] REG_SJW    = 2'd2;

  localparam logic [Seg1Width-1:0] PHASE1_RESET = 5'd8;
  localparam logic [Seg2Width-1:0] PHASE2_RESET = 4'd4;
  localparam logic [SjwWidth-1:0]  SJW_RESET    = 3'd1;

  typedef struct packed {
    logic [Seg1Width-1:0] phase1_quanta;
    logic [Seg2Width-1:0] phase2_quanta;
    logic [SjwWidth-1:0]  jump_width;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            segment_state;
    logic [CountWidth-1:0] quantum_count;
    logic [Seg1Width-1:0]  seg1_length;
    logic [Seg2Width-1:0]  seg2_length;
    logic                  edge_pending;
  } state_t;

  typedef struct packed {
    logic       write_point;
    logic       sample_point;
    logic [1:0] segment;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/cbts_tick_if.sv =====
`default_nettype none
interface cbts_tick_if;
  logic valid;
  logic ready;
  logic edge_seen;
  logic bus_idle;

  modport source (output valid, output edge_seen, output bus_idle, input ready);
  modport sink (input valid, input edge_seen, input bus_idle, output ready);
endinterface
`default_nettype wire

// ===== rtl/cbts_timing_if.sv =====
`default_nettype none
interface cbts_timing_if;
  logic       valid;
  logic       ready;
  logic       write_point;
  logic       sample_point;
  logic [1:0] segment;

  modport source (output valid, output write_point, output sample_point, output segment,
                  input ready);
  modport sink (input valid, input write_point, input sample_point, input segment,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/can_bit_timing_sync_top.sv =====
`default_nettype none
// Channel  Direction  Payload                               Meaning
// tick     sink       edge_seen, bus_idle                   one time quantum
// timing   source     write_point, sample_point, segment    result for that quantum
// cfg      write      cfg_index 0..2, cfg_data 5 bits       phase1, phase2, jump width
//
// One tick is taken per cycle while tick.ready is high; its result appears in the output register on the
// next cycle. The timing state updates in the same cycle the tick transfers.
// A result held under backpressure still lets a new tick in when it is taken
// that cycle (ready follows the output register's free/draining status).
// Synchronous reset restores the default register values and the sync segment.
module can_bit_timing_sync_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write_en,
  input  wire logic [cbts_pkg::IndexWidth-1:0]  cfg_index,
  input  wire logic [cbts_pkg::CfgWidth-1:0]    cfg_data,
  cbts_tick_if.sink                             tick,
  cbts_timing_if.source                         timing
);

  cbts_pkg::cfg_t    cfg;
  cbts_pkg::state_t  state;
  cbts_pkg::state_t  state_next;
  cbts_pkg::result_t result_next;
  cbts_pkg::result_t result;
  logic              out_valid;
  logic              accept;

  assign tick.ready = !out_valid || timing.ready;
  assign accept     = tick.valid && tick.ready;

  cbts_core u_core (
    .cfg       (cfg),
    .cur       (state),
    .edge_seen (tick.edge_seen),
    .bus_idle  (tick.bus_idle),
    .nxt       (state_next),
    .res       (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase1_quanta <= cbts_pkg::PHASE1_RESET;
      cfg.phase2_quanta <= cbts_pkg::PHASE2_RESET;
      cfg.jump_width    <= cbts_pkg::SJW_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        cbts_pkg::REG_PHASE1: cfg.phase1_quanta <= cfg_data;
        cbts_pkg::REG_PHASE2: cfg.phase2_quanta <= cfg_data[cbts_pkg::Seg2Width-1:0];
        cbts_pkg::REG_SJW:    cfg.jump_width    <= cfg_data[cbts_pkg::SjwWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.segment_state <= cbts_pkg::SEG_SYNC;
      state.quantum_count <= '0;
      state.seg1_length   <= '0;
      state.seg2_length   <= '0;
      state.edge_pending  <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (timing.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) result <= result_next;
  end

  assign timing.valid        = out_valid;
  assign timing.write_point  = result.write_point;
  assign timing.sample_point = result.sample_point;
  assign timing.segment      = result.segment;

endmodule
`default_nettype wire

// ===== rtl/cbts_core.sv =====
`default_nettype none
module cbts_core (
  input  wire cbts_pkg::cfg_t    cfg,
  input  wire cbts_pkg::state_t  cur,
  input  wire logic              edge_seen,
  input  wire logic              bus_idle,
  output cbts_pkg::state_t       nxt,
  output cbts_pkg::result_t      res
);

  logic [1:0]                       seg;
  logic                             pending;
  logic [cbts_pkg::CountWidth-1:0]  jw_ext;
  logic [cbts_pkg::CountWidth-1:0]  seg1_ext;
  logic [cbts_pkg::SjwWidth-1:0]    p1_adj;
  logic [cbts_pkg::CountWidth-1:0]  p1_sum;
  logic [cbts_pkg::Seg1Width-1:0]   seg1_grown;
  logic [cbts_pkg::Seg1Width-1:0]   seg1_p1;
  logic [cbts_pkg::CountWidth-1:0]  end_nom;
  logic [cbts_pkg::CountWidth-1:0]  span;
  logic [cbts_pkg::SjwWidth-1:0]    p2_adj;
  logic [cbts_pkg::Seg2Width-1:0]   seg2_cut;
  logic [cbts_pkg::Seg2Width-1:0]   seg2_p2;
  logic [cbts_pkg::CountWidth-1:0]  end_p2;
  logic                             p1_resync;
  logic                             p2_resync;
  logic [cbts_pkg::CountWidth-1:0]  count_base;

  always_comb begin
    jw_ext   = {{(cbts_pkg::CountWidth-cbts_pkg::SjwWidth){1'b0}}, cfg.jump_width};
    seg1_ext = {1'b0, cur.seg1_length};

    // phase 1: lengthen by min(sjw, elapsed), saturating at 31
    p1_adj     = (cur.quantum_count < jw_ext) ? cur.quantum_count[cbts_pkg::SjwWidth-1:0]
                                              : cfg.jump_width;
    p1_sum     = seg1_ext + {{(cbts_pkg::CountWidth-cbts_pkg::SjwWidth){1'b0}}, p1_adj};
    seg1_grown = p1_sum[cbts_pkg::Seg1Width] ? {cbts_pkg::Seg1Width{1'b1}}
                                             : p1_sum[cbts_pkg::Seg1Width-1:0];

    // phase 2: shorten by min(sjw, |end - count|), floor at zero
    end_nom  = seg1_ext + {2'b00, cur.seg2_length};
    span     = (end_nom >= cur.quantum_count) ? end_nom - cur.quantum_count
                                              : cur.quantum_count - end_nom;
    p2_adj   = (span < jw_ext) ? span[cbts_pkg::SjwWidth-1:0] : cfg.jump_width;
    seg2_cut = ({1'b0, p2_adj} >= cur.seg2_length) ? '0
                                                   : cur.seg2_length - {1'b0, p2_adj};

    pending = cur.edge_pending | edge_seen;
    seg     = (edge_seen && bus_idle) ? cbts_pkg::SEG_HS : cur.segment_state;

    p1_resync = pending && (cur.seg1_length == cfg.phase1_quanta);
    p2_resync = pending && (cur.seg2_length == cfg.phase2_quanta);
    seg1_p1   = p1_resync ? seg1_grown : cur.seg1_length;
    seg2_p2   = p2_resync ? seg2_cut : cur.seg2_length;
    end_p2    = seg1_ext + {2'b00, seg2_p2};

    nxt              = cur;
    nxt.edge_pending = pending;
    count_base       = cur.quantum_count;
    res.write_point  = 1'b0;
    res.sample_point = 1'b0;
    res.segment      = seg;

    case (seg)
      cbts_pkg::SEG_P1: begin
        nxt.seg1_length = seg1_p1;
        if (p1_resync) nxt.edge_pending = 1'b0;
        if (cur.quantum_count == {1'b0, seg1_p1}) begin
          res.sample_point  = 1'b1;
          nxt.segment_state = cbts_pkg::SEG_P2;
        end else begin
          nxt.segment_state = cbts_pkg::SEG_P1;
        end
      end
      cbts_pkg::SEG_P2: begin
        nxt.seg2_length = seg2_p2;
        if (p2_resync) nxt.edge_pending = 1'b0;
        nxt.segment_state = (cur.quantum_count == end_p2) ? cbts_pkg::SEG_SYNC
                                                          : cbts_pkg::SEG_P2;
      end
      default: begin
        // sync and hard sync restart the bit; only sync marks the write point
        count_base        = '0;
        nxt.seg1_length   = cfg.phase1_quanta;
        nxt.seg2_length   = cfg.phase2_quanta;
        nxt.edge_pending  = 1'b0;
        nxt.segment_state = cbts_pkg::SEG_P1;
        res.write_point   = (seg == cbts_pkg::SEG_SYNC);
      end
    endcase

    nxt.quantum_count = count_base + 1'b1;
  end

endmodule
`default_nettype wire

// ===== bench/can_bit_timing_sync_checker.sv =====
`timescale 1ns / 100ps
module can_bit_timing_sync_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [cbts_pkg::IndexWidth-1:0] cfg_index,
  input  logic [cbts_pkg::CfgWidth-1:0]   cfg_data,
  cbts_tick_if                            tick,
  cbts_timing_if                          timing,
  output int                              mismatch_count,
  output int                              results_owed
);

  typedef logic [cbts_pkg::Seg1Width-1:0]  len1_t;
  typedef logic [cbts_pkg::Seg2Width-1:0]  len2_t;
  typedef logic [cbts_pkg::CountWidth-1:0] count_t;

  // register copies
  len1_t                         phase1_len;
  len2_t                         phase2_len;
  logic [cbts_pkg::SjwWidth-1:0] sjw;

  // bit timing state
  logic [1:0] seg_state;
  count_t     quanta;
  len1_t      seg1_len;
  len2_t      seg2_len;
  logic       edge_pend;

  cbts_pkg::result_t timing_due[$];
  int                fail_tally = 0;
  int                owed_q = 0;

  assign mismatch_count = fail_tally;
  assign results_owed   = owed_q;

  function automatic cbts_pkg::result_t advance_quantum(input logic edge_seen,
                                                        input logic bus_idle);
    cbts_pkg::result_t res;
    logic [1:0]        seg;
    int                adj;
    int                stop;
    int                span;
    int                grown;
    res = '0;
    if (edge_seen) begin
      edge_pend = 1'b1;
      if (bus_idle) seg_state = cbts_pkg::SEG_HS;
    end
    seg = seg_state;
    case (seg)
      cbts_pkg::SEG_SYNC: begin
        quanta    = '0;
        seg1_len  = phase1_len;
        seg2_len  = phase2_len;
        edge_pend = 1'b0;
        res.write_point = 1'b1;
        seg_state = cbts_pkg::SEG_P1;
      end
      cbts_pkg::SEG_P1: begin
        // lengthen once per bit, only while still at the nominal length
        if (edge_pend && seg1_len == phase1_len) begin
          adj = (int'(sjw) < int'(quanta)) ? int'(sjw) : int'(quanta);
          edge_pend = 1'b0;
          grown = int'(seg1_len) + adj;
          seg1_len = len1_t'((grown > 31) ? 31 : grown);
        end
        if (int'(quanta) == int'(seg1_len)) begin
          res.sample_point = 1'b1;
          seg_state = cbts_pkg::SEG_P2;
        end
      end
      cbts_pkg::SEG_P2: begin
        stop = int'(seg1_len) + int'(seg2_len);
        if (edge_pend && seg2_len == phase2_len) begin
          span = (stop >= int'(quanta)) ? stop - int'(quanta) : int'(quanta) - stop;
          adj = (int'(sjw) < span) ? int'(sjw) : span;
          edge_pend = 1'b0;
          seg2_len = (adj >= int'(seg2_len)) ? '0 : len2_t'(int'(seg2_len) - adj);
          stop = int'(seg1_len) + int'(seg2_len);
        end
        if (int'(quanta) == stop) seg_state = cbts_pkg::SEG_SYNC;
      end
      default: begin
        quanta    = '0;
        seg1_len  = phase1_len;
        seg2_len  = phase2_len;
        edge_pend = 1'b0;
        seg_state = cbts_pkg::SEG_P1;
      end
    endcase
    quanta = quanta + count_t'(1);
    res.segment = seg;
    return res;
  endfunction

  always @(posedge clk) begin
    cbts_pkg::result_t got;
    cbts_pkg::result_t want;
    if (rst) begin
      phase1_len = cbts_pkg::PHASE1_RESET;
      phase2_len = cbts_pkg::PHASE2_RESET;
      sjw        = cbts_pkg::SJW_RESET;
      seg_state  = cbts_pkg::SEG_SYNC;
      quanta     = '0;
      seg1_len   = '0;
      seg2_len   = '0;
      edge_pend  = 1'b0;
      timing_due.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          cbts_pkg::REG_PHASE1: phase1_len = cfg_data[cbts_pkg::Seg1Width-1:0];
          cbts_pkg::REG_PHASE2: phase2_len = cfg_data[cbts_pkg::Seg2Width-1:0];
          cbts_pkg::REG_SJW:    sjw        = cfg_data[cbts_pkg::SjwWidth-1:0];
          default: ;
        endcase
      end
      // results leave before the tick of this edge is predicted
      if (timing.valid && timing.ready) begin
        got.write_point  = timing.write_point;
        got.sample_point = timing.sample_point;
        got.segment      = timing.segment;
        if (timing_due.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("%0t: unexpected result wp=%0b sp=%0b seg=%0d", $time,
                     got.write_point, got.sample_point, got.segment);
        end else begin
          want = timing_due.pop_front();
          if (got.write_point !== want.write_point || got.sample_point !== want.sample_point ||
              got.segment !== want.segment) begin
            fail_tally++;
            if (fail_tally <= 10)
              $display("%0t: mismatch expected wp=%0b sp=%0b seg=%0d, got wp=%0b sp=%0b seg=%0d",
                       $time, want.write_point, want.sample_point, want.segment,
                       got.write_point, got.sample_point, got.segment);
          end
        end
      end
      if (tick.valid && tick.ready)
        timing_due.push_back(advance_quantum(tick.edge_seen, tick.bus_idle));
    end
    owed_q <= timing_due.size();
  end

endmodule

// ===== bench/can_bit_timing_sync_top_tb.sv =====
`timescale 1ns / 100ps
module can_bit_timing_sync_top_tb;

  localparam logic [cbts_pkg::IndexWidth-1:0] REG_UNUSED = 2'd3;
  localparam int CycleLimit    = 300000;
  localparam int BitPhases     = 12;
  localparam int TicksPerPhase = 78;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write_en = 1'b0;
  logic [cbts_pkg::IndexWidth-1:0] cfg_index = '0;
  logic [cbts_pkg::CfgWidth-1:0]   cfg_data = '0;

  int mismatch_count;
  int results_owed;
  int cycle_count = 0;
  int burst_left = 0;
  int ready_cycles = 0;
  int ready_mode = 0;

  cbts_tick_if   tick_ch();
  cbts_timing_if timing_ch();

  can_bit_timing_sync_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tick         (tick_ch),
    .timing       (timing_ch)
  );

  can_bit_timing_sync_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .tick           (tick_ch),
    .timing         (timing_ch),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver backpressure: one of four ready modes, chosen at random
  always @(posedge clk) begin
    if (ready_cycles == 0) begin
      ready_mode   <= $urandom_range(0, 3);
      ready_cycles <= $urandom_range(8, 80);
    end else begin
      ready_cycles <= ready_cycles - 1;
    end
    case (ready_mode)
      0:       timing_ch.ready <= 1'b1;
      1:       timing_ch.ready <= ($urandom_range(0, 3) != 0);
      2:       timing_ch.ready <= ($urandom_range(0, 3) == 0);
      default: timing_ch.ready <= ((cycle_count % 3) != 0);
    endcase
  end

  task automatic send_tick(input logic edge_seen, input logic bus_idle);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) begin
          tick_ch.edge_seen <= 1'($urandom_range(0, 1));
          tick_ch.bus_idle  <= 1'($urandom_range(0, 1));
          @(posedge clk);
        end
      end
    end
    burst_left--;
    tick_ch.valid     <= 1'b1;
    tick_ch.edge_seen <= edge_seen;
    tick_ch.bus_idle  <= bus_idle;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  task automatic wait_drained;
    tick_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // writes all registers back to back; only call with the block idle
  task automatic load_timing(input logic [cbts_pkg::CfgWidth-1:0] p1_data,
                             input logic [cbts_pkg::CfgWidth-1:0] p2_data,
                             input logic [cbts_pkg::CfgWidth-1:0] sjw_data);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_index    <= cbts_pkg::REG_PHASE1;
    cfg_data     <= p1_data;
    @(posedge clk);
    cfg_index <= cbts_pkg::REG_PHASE2;
    cfg_data  <= p2_data;
    @(posedge clk);
    cfg_index <= cbts_pkg::REG_SJW;
    cfg_data  <= sjw_data;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= cbts_pkg::CfgWidth'($urandom_range(0, 31));
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    int   edge_pct;
    logic idle_bus;
    tick_ch.valid     = 1'b0;
    tick_ch.edge_seen = 1'b0;
    tick_ch.bus_idle  = 1'b0;
    timing_ch.ready   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset timing: hard sync, lengthening in phase 1, shortening in phase 2
    for (int i = 0; i < 20; i++)
      send_tick(i == 1 || i == 4 || i == 7 || i == 14 || i == 19,
                i == 1 || i == 2 || i == 19);
    // one-quantum segments, jump width 4
    load_timing(5'd1, 5'd1, 5'd4);
    for (int i = 0; i < 6; i++) send_tick(1'(i % 2), 1'b0);

    idle_bus = 1'b0;
    for (int phase = 0; phase < BitPhases; phase++) begin
      case (phase)
        0: load_timing(5'd1, 5'd1, 5'd1);
        1: load_timing(5'd16, 5'd8, 5'd4);
        2: load_timing(5'd31, 5'd1, 5'd7);     // saturating phase 1, phase 2 down to zero
        3: load_timing(5'd0, 5'd0, 5'd0);      // zero lengths: count wraps before the match
        4: load_timing(5'h1F, 5'h1F, 5'h1F);
        5: load_timing(5'd2, 5'd16, 5'd3);     // upper bit dropped, phase 2 becomes zero
        default: begin
          if ($urandom_range(0, 3) == 0)
            load_timing(cbts_pkg::CfgWidth'($urandom_range(0, 31)),
                        cbts_pkg::CfgWidth'($urandom_range(0, 31)),
                        cbts_pkg::CfgWidth'($urandom_range(0, 31)));
          else
            load_timing(cbts_pkg::CfgWidth'($urandom_range(1, 16)),
                        cbts_pkg::CfgWidth'($urandom_range(1, 8)),
                        cbts_pkg::CfgWidth'($urandom_range(1, 4)));
        end
      endcase
      edge_pct = $urandom_range(3, 40);
      for (int i = 0; i < TicksPerPhase; i++) begin
        if ($urandom_range(0, 19) == 0) idle_bus = ~idle_bus;
        if ($urandom_range(0, 149) == 0) wait_drained();
        send_tick($urandom_range(0, 99) < edge_pct, idle_bus);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
